FILE: hdl/i2cmbs_pkg.sv
// Shared types and the phase table of the I2C master bit sequencer.
// Used by i2cmbs_ctrl, i2cmbs_datapath and the top level; no dependencies.
package i2cmbs_pkg;

   localparam int TICK_W      = 16;
   localparam int IDX_W       = 6;
   localparam int BYTE_W      = 8;
   localparam logic [TICK_W-1:0] TICKS_RESET = 16'd10;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACT_HOLD = 2'd0,
      ACT_SCL  = 2'd1,
      ACT_SDA  = 2'd2
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef struct packed {
      act_type act;
      logic    val;
      logic    last;
      logic    shift;
   } phase_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic last;
   } status_type;

   function automatic phase_type phase_decode(op_type op, logic [IDX_W-1:0] idx,
                                              logic tx_msb);
      phase_type p;
      p = '{act: ACT_HOLD, val: 1'b0, last: 1'b0, shift: 1'b0};
      unique case (op)
         OP_START: begin
            case (idx)
               6'd0: begin p.act = ACT_SCL; p.val = 1'b1; end
               6'd1: begin p.act = ACT_SDA; p.val = 1'b1; end
               6'd3: begin p.act = ACT_SDA; p.val = 1'b0; end
               6'd5: begin p.act = ACT_SCL; p.val = 1'b0; p.last = 1'b1; end
               default: p.act = ACT_HOLD;
            endcase
         end
         OP_STOP: begin
            case (idx)
               6'd0: begin p.act = ACT_SDA; p.val = 1'b0; end
               6'd2: begin p.act = ACT_SCL; p.val = 1'b1; end
               6'd4: begin p.act = ACT_SDA; p.val = 1'b1; p.last = 1'b1; end
               default: p.act = ACT_HOLD;
            endcase
         end
         OP_WRITE: begin
            case (idx[1:0])
               2'd0: begin p.act = ACT_SDA; p.val = idx[5] ? 1'b1 : tx_msb; end
               2'd1: begin p.act = ACT_SCL; p.val = 1'b1; end
               2'd3: begin
                  p.act   = ACT_SCL;
                  p.val   = 1'b0;
                  p.shift = ~idx[5];
                  p.last  = idx[5];
               end
               default: p.act = ACT_HOLD;
            endcase
         end
         OP_READ: begin
            if (idx == '0) begin
               p.act = ACT_SDA; p.val = 1'b1;
            end else begin
               p.act  = ACT_SCL;
               p.val  = idx[0];
               p.last = (idx == 6'd16);
            end
         end
      endcase
      return p;
   endfunction

endpackage

FILE: hdl/i2cmbs_ctrl.sv
// Controller state machine of the I2C master bit sequencer.
// Depends on i2cmbs_pkg; drives the datapath through cmd_type.
module i2cmbs_ctrl
   import i2cmbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!status.busy) begin
               cmd.emit = 1'b1;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.done && !status.busy) begin
               state_in = status.last ? ST_IDLE : ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/i2cmbs_datapath.sv
// Datapath of the I2C master bit sequencer: line levels, transmit shift register,
// receive register, phase counter, hold timer, config register and output word register.
// Depends on i2cmbs_pkg.
module i2cmbs_datapath
   import i2cmbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [1:0]        req_op,
   input  logic [BYTE_W-1:0] req_write_data,
   input  logic [BYTE_W-1:0] req_sda_samples,
   input  logic              req_ack_sample,
   input  logic              csr_valid,
   input  logic [TICK_W-1:0] csr_phase_ticks,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_scl_release,
   output logic              rsp_sda_release,
   output logic              rsp_last_phase,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_nack
);

   op_type            op_ff;
   logic [BYTE_W-1:0] tx_ff, rx_ff;
   logic              ack_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              scl_ff, sda_ff, scl_in, sda_in;
   logic              last_ff;
   logic [TICK_W-1:0] ticks_ff, cnt_ff;
   logic              rsp_valid_ff;
   logic              rsp_scl_ff, rsp_sda_ff, rsp_last_ff, rsp_nack_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   phase_type         ph;

   assign ph = phase_decode(op_ff, idx_ff, tx_ff[BYTE_W-1]);

   assign scl_in = (ph.act == ACT_SCL) ? ph.val : scl_ff;
   assign sda_in = (ph.act == ACT_SDA) ? ph.val : sda_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         idx_ff       <= '0;
         tx_ff        <= '0;
         last_ff      <= 1'b0;
         ticks_ff     <= TICKS_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            ticks_ff <= csr_phase_ticks;
         end
         if (cmd.load) begin
            idx_ff  <= '0;
            tx_ff   <= req_write_data;
            last_ff <= 1'b0;
         end
         if (cmd.emit) begin
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            last_ff      <= ph.last;
            idx_ff       <= ph.last ? '0 : idx_ff + 1'b1;
            cnt_ff       <= (ticks_ff == '0) ? '0 : ticks_ff - 1'b1;
            rsp_valid_ff <= 1'b1;
            if (ph.shift) begin
               tx_ff <= {tx_ff[BYTE_W-2:0], 1'b0};
            end
         end else begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
            end
            if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_op);
         rx_ff  <= req_sda_samples;
         ack_ff <= req_ack_sample;
      end
      if (cmd.emit) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_last_ff <= ph.last;
         rsp_byte_ff <= (ph.last && op_ff == OP_READ) ? rx_ff : '0;
         rsp_nack_ff <= ph.last && op_ff == OP_WRITE && ack_ff;
      end
   end

   assign status.busy = rsp_valid_ff & ~rsp_ready;
   assign status.done = (cnt_ff == '0);
   assign status.last = last_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_release = rsp_scl_ff;
   assign rsp_sda_release = rsp_sda_ff;
   assign rsp_last_phase  = rsp_last_ff;
   assign rsp_read_byte   = rsp_byte_ff;
   assign rsp_nack        = rsp_nack_ff;

endmodule

FILE: hdl/i2c_master_bit_sequencer_unit.sv
// I2C master bit sequencer. Each command word (start, stop, write byte,
// read byte) yields a run of bus-phase words: start 6, stop 5, write 36,
// read 17. Each phase word carries the SCL and SDA release levels; the
// final one flags last_phase and carries nack or read_byte. One command is
// processed at a time: each phase is held by the hold timer, loaded from
// phase_ticks, and longer while the previous phase word waits on rsp_ready;
// a command is taken only in the idle state. csr writes take effect
// on the next phase. Depends on i2cmbs_pkg, i2cmbs_ctrl, i2cmbs_datapath.
module i2c_master_bit_sequencer_unit
   import i2cmbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [BYTE_W-1:0] req_write_data,
   input  logic [BYTE_W-1:0] req_sda_samples,
   input  logic              req_ack_sample,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_scl_release,
   output logic              rsp_sda_release,
   output logic              rsp_last_phase,
   output logic [BYTE_W-1:0] rsp_read_byte,
   output logic              rsp_nack,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [TICK_W-1:0] csr_phase_ticks
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   i2cmbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   i2cmbs_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_write_data  (req_write_data),
      .req_sda_samples (req_sda_samples),
      .req_ack_sample  (req_ack_sample),
      .csr_valid       (csr_valid),
      .csr_phase_ticks (csr_phase_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_release (rsp_scl_release),
      .rsp_sda_release (rsp_sda_release),
      .rsp_last_phase  (rsp_last_phase),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_nack        (rsp_nack)
   );

endmodule
